>>> hw/rtl/assert_macros.svh
// assertion macros shared by the checker files
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, ignored while reset is asserted
`define OPT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("opt assertion failed");

// clocked assertion that is also checked during reset
`define OPT_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("opt assertion failed");

`endif

>>> hw/rtl/opt_pkg.sv
// types, constants and saturation helpers for the one-pole tpt filter
// no dependencies
package opt_pkg;

    localparam int CHANNELS       = 8;
    localparam int SAMPLE_BITS    = 24;
    localparam int COEF_FRAC_BITS = 18;

    localparam int CH_FIELD_BITS  = 3;
    localparam int CH_IDX_BITS    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int COEF_BITS      = COEF_FRAC_BITS + 1;
    localparam int STATE_BITS     = SAMPLE_BITS + 2;
    localparam int DIFF_BITS      = STATE_BITS + 1;
    localparam int PROD_BITS      = DIFF_BITS + COEF_BITS + 1;
    localparam int SUM_BITS       = STATE_BITS + 5;
    localparam int SNAP_BITS      = 8;

    localparam int QUEUE_DEPTH    = 2;
    localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS      = $clog2(QUEUE_DEPTH + 1);

    // apb register map
    localparam int REG_IDX_BITS   = 2;
    localparam int PADDR_BITS     = REG_IDX_BITS + 2;
    localparam int PDATA_BITS     = 32;

    typedef logic [REG_IDX_BITS-1:0] t_reg_idx;
    localparam t_reg_idx REG_COEF = 2'd0;
    localparam t_reg_idx REG_MODE = 2'd1;
    localparam t_reg_idx REG_SNAP = 2'd2;

    typedef logic [1:0] t_act;
    localparam t_act ACT_FILTER = 2'd0;
    localparam t_act ACT_SNAP   = 2'd1;
    localparam t_act ACT_CLEAR  = 2'd2;

    localparam logic [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(1) << COEF_FRAC_BITS;

    typedef struct packed {
        t_act                          act;
        logic [CH_IDX_BITS-1:0]        chan;
        logic signed [SAMPLE_BITS-1:0] sample;
    } t_entry;

    typedef struct packed {
        logic [COEF_BITS-1:0] coef;
        logic                 hp_mode;
        logic [SNAP_BITS-1:0] snap_level;
    } t_cfg;

    localparam logic signed [SUM_BITS-1:0] SMP_MAX =
        SUM_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [SUM_BITS-1:0] SMP_MIN = -SMP_MAX - SUM_BITS'(1);
    localparam logic signed [SUM_BITS-1:0] ST_MAX =
        SUM_BITS'((64'sd1 <<< (STATE_BITS - 1)) - 64'sd1);
    localparam logic signed [SUM_BITS-1:0] ST_MIN = -ST_MAX - SUM_BITS'(1);

    function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
        input logic signed [SUM_BITS-1:0] a
    );
        logic signed [SUM_BITS-1:0] r;
        if (a > SMP_MAX) begin
            r = SMP_MAX;
        end else if (a < SMP_MIN) begin
            r = SMP_MIN;
        end else begin
            r = a;
        end
        return r[SAMPLE_BITS-1:0];
    endfunction

    function automatic logic signed [STATE_BITS-1:0] sat_state(
        input logic signed [SUM_BITS-1:0] a
    );
        logic signed [SUM_BITS-1:0] r;
        if (a > ST_MAX) begin
            r = ST_MAX;
        end else if (a < ST_MIN) begin
            r = ST_MIN;
        end else begin
            r = a;
        end
        return r[STATE_BITS-1:0];
    endfunction

endpackage

>>> hw/rtl/opt_front.sv
// front end: classifies accepted items and drops the ones that do nothing
// depends on opt_pkg
module opt_front (
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    input  opt_pkg::t_act                     i_action,
    input  logic [opt_pkg::CH_FIELD_BITS-1:0] i_channel_index,
    input  logic signed [opt_pkg::SAMPLE_BITS-1:0] i_sample_in,
    output logic                              o_push,
    output opt_pkg::t_entry                   o_entry
);
    import opt_pkg::*;

    logic act_ok;
    logic chan_ok;

    always_comb begin
        unique case (i_action) inside
            ACT_FILTER, ACT_SNAP, ACT_CLEAR: act_ok = 1'b1;
            default:                         act_ok = 1'b0;
        endcase
    end

    assign chan_ok = (int'(i_channel_index) < CHANNELS);

    assign o_push         = i_in_valid && i_in_ready && act_ok && chan_ok;
    assign o_entry.act    = i_action;
    assign o_entry.chan   = CH_IDX_BITS'(i_channel_index);
    assign o_entry.sample = i_sample_in;

endmodule

>>> hw/rtl/opt_queue.sv
// short fifo between the front end and the execute stage
// depends on opt_pkg
module opt_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  opt_pkg::t_entry i_entry,
    output logic            o_full,
    output logic            o_valid,
    output opt_pkg::t_entry o_entry,
    input  logic            i_pop
);
    import opt_pkg::*;

    t_entry                 r_slot [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QPTR_BITS-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QCNT_BITS-1:0]   r_count, n_count;
    logic                   do_pop;

    assign o_full  = (r_count == QCNT_BITS'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_slot[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + QPTR_BITS'(1) : r_wr_ptr;
        n_rd_ptr = do_pop ? r_rd_ptr + QPTR_BITS'(1) : r_rd_ptr;
        n_count  = r_count + QCNT_BITS'(i_push) - QCNT_BITS'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_entry;
        end
    end

endmodule

>>> hw/rtl/opt_back.sv
// execute stage: per-channel integrator update and the result register
// depends on opt_pkg
module opt_back (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  opt_pkg::t_cfg                          i_cfg,
    input  logic                                   i_q_valid,
    input  opt_pkg::t_entry                        i_q_entry,
    output logic                                   o_q_pop,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [opt_pkg::SAMPLE_BITS-1:0] o_lowpass_out,
    output logic signed [opt_pkg::SAMPLE_BITS-1:0] o_highpass_out,
    output logic signed [opt_pkg::SAMPLE_BITS-1:0] o_selected_out
);
    import opt_pkg::*;

    logic signed [STATE_BITS-1:0]  r_state [CHANNELS];
    logic                          r_out_valid, n_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_lp, r_hp, r_sel;

    logic                          slot_free;
    logic signed [STATE_BITS-1:0]  s;
    logic signed [DIFF_BITS-1:0]   diff;
    logic signed [COEF_BITS:0]     g_eff;
    logic signed [PROD_BITS-1:0]   prod;
    logic signed [PROD_BITS-1:0]   prod_rnd;
    logic signed [SUM_BITS-1:0]    v, lp, hp, st;
    logic signed [STATE_BITS-1:0]  snap_hi, snap_lo;
    logic                          in_snap_band;
    logic signed [SAMPLE_BITS-1:0] lp_sat, hp_sat;
    logic                          do_filter, do_zero;

    assign slot_free = !r_out_valid || i_out_ready;
    // snap and clear never need the result slot
    assign o_q_pop = i_q_valid && ((i_q_entry.act != ACT_FILTER) || slot_free);

    assign s = r_state[i_q_entry.chan];

    always_comb begin
        g_eff    = (i_cfg.coef > COEF_ONE) ? {1'b0, COEF_ONE} : {1'b0, i_cfg.coef};
        diff     = DIFF_BITS'(i_q_entry.sample) - DIFF_BITS'(s);
        prod     = PROD_BITS'(diff) * PROD_BITS'(g_eff);
        // round half up, then floor shift
        prod_rnd = prod + (PROD_BITS'(1) <<< (COEF_FRAC_BITS - 1));
        v        = SUM_BITS'(prod_rnd >>> COEF_FRAC_BITS);
        lp       = SUM_BITS'(s) + v;
        hp       = SUM_BITS'(i_q_entry.sample) - lp;
        st       = lp + v;
        lp_sat   = sat_sample(lp);
        hp_sat   = sat_sample(hp);
    end

    always_comb begin
        snap_hi      = STATE_BITS'(i_cfg.snap_level);
        snap_lo      = -snap_hi;
        in_snap_band = (s <= snap_hi) && (s >= snap_lo);
    end

    always_comb begin
        do_filter = 1'b0;
        do_zero   = 1'b0;
        unique case (i_q_entry.act)
            ACT_FILTER: do_filter = o_q_pop;
            ACT_SNAP:   do_zero   = o_q_pop && in_snap_band;
            ACT_CLEAR:  do_zero   = o_q_pop;
            default:    ;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (do_filter) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_state[i] <= '0;
            end
        end else begin
            r_out_valid <= n_out_valid;
            if (do_filter) begin
                r_state[i_q_entry.chan] <= sat_state(st);
            end else if (do_zero) begin
                r_state[i_q_entry.chan] <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_filter) begin
            r_lp  <= lp_sat;
            r_hp  <= hp_sat;
            r_sel <= i_cfg.hp_mode ? hp_sat : lp_sat;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_lowpass_out  = r_lp;
    assign o_highpass_out = r_hp;
    assign o_selected_out = r_sel;

endmodule

>>> hw/rtl/one_pole_tpt_filter.sv
// one-pole tpt filter: apb registers, front end, queue and execute stage
// depends on opt_pkg, opt_front, opt_queue, opt_back
// usage:
//   input channel: i_in_valid / o_in_ready with i_action, i_channel_index,
//   i_sample_in. a filter beat yields one result beat; snap and clear beats
//   and beats with an unknown action or channel yield none.
//   output channel: o_out_valid / i_out_ready with o_lowpass_out,
//   o_highpass_out and o_selected_out.
//   registers over apb: coefficient at 0x0, highpass_mode at 0x4, snap_level
//   at 0x8; write only while no beat is in flight.
// timing:
//   a beat waits in the queue; when the execute stage pops it, its channel
//   state and result register update at the same edge, and the result is on
//   the output from then on. one beat per cycle is sustained while the output
//   is not stalled; the per-channel state loop (subtract, multiply, round,
//   add) is combinational, so consecutive same-channel beats see updated state.
// reset: synchronous, active low; channel states, registers and the queue
//   clear, o_in_ready is low while reset is held.
// stall: a held result stays on the output; snap and clear beats still drain
//   the two-entry queue, and o_in_ready drops when the queue fills.
module one_pole_tpt_filter (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [opt_pkg::PADDR_BITS-1:0]         paddr,
    input  logic [opt_pkg::PDATA_BITS-1:0]         pwdata,
    output logic [opt_pkg::PDATA_BITS-1:0]         prdata,
    output logic                                   pready,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic [1:0]                             i_action,
    input  logic [opt_pkg::CH_FIELD_BITS-1:0]      i_channel_index,
    input  logic signed [opt_pkg::SAMPLE_BITS-1:0] i_sample_in,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [opt_pkg::SAMPLE_BITS-1:0] o_lowpass_out,
    output logic signed [opt_pkg::SAMPLE_BITS-1:0] o_highpass_out,
    output logic signed [opt_pkg::SAMPLE_BITS-1:0] o_selected_out
);
    import opt_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    logic     push, q_full, q_valid, q_pop;
    t_entry   f_entry, q_entry;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_BITS-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_COEF: r_cfg.coef       <= pwdata[COEF_BITS-1:0];
                REG_MODE: r_cfg.hp_mode    <= pwdata[0];
                REG_SNAP: r_cfg.snap_level <= pwdata[SNAP_BITS-1:0];
                default:  ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_COEF: prdata = PDATA_BITS'(r_cfg.coef);
            REG_MODE: prdata = PDATA_BITS'(r_cfg.hp_mode);
            REG_SNAP: prdata = PDATA_BITS'(r_cfg.snap_level);
            default:  prdata = '0;
        endcase
    end

    assign o_in_ready = i_rst_n && !q_full;

    opt_front u_front (
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_action        (i_action),
        .i_channel_index (i_channel_index),
        .i_sample_in     (i_sample_in),
        .o_push          (push),
        .o_entry         (f_entry)
    );

    opt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (f_entry),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_entry (q_entry),
        .i_pop   (q_pop)
    );

    opt_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_q_valid      (q_valid),
        .i_q_entry      (q_entry),
        .o_q_pop        (q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_lowpass_out  (o_lowpass_out),
        .o_highpass_out (o_highpass_out),
        .o_selected_out (o_selected_out)
    );

endmodule

>>> hw/rtl/opt_checker.sv
// port-level checks for the one-pole tpt filter, bound to the top level
// depends on opt_pkg and assert_macros.svh
`include "assert_macros.svh"

module opt_checker (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   o_out_valid,
    input logic                                   i_out_ready,
    input logic signed [opt_pkg::SAMPLE_BITS-1:0] o_lowpass_out,
    input logic signed [opt_pkg::SAMPLE_BITS-1:0] o_highpass_out,
    input logic signed [opt_pkg::SAMPLE_BITS-1:0] o_selected_out
);
    import opt_pkg::*;

    logic stalled;
    logic sel_ok;

    assign stalled = o_out_valid && !i_out_ready;
    assign sel_ok  = (o_selected_out == o_lowpass_out) ||
                     (o_selected_out == o_highpass_out);

    // a stalled result beat stays
    `OPT_ASSERT(a_out_hold, i_clk, i_rst_n, stalled |=> o_out_valid)

    // stalled selected output holds
    `OPT_ASSERT(a_out_stable, i_clk, i_rst_n, stalled |=> $stable(o_selected_out))

    // while a result is valid, the selected output is one of the two filter outputs
    `OPT_ASSERT(a_sel_pick, i_clk, i_rst_n, o_out_valid |-> sel_ok)

    // nothing comes out right after reset
    `OPT_ASSERT_NR(a_reset_quiet, i_clk, !i_rst_n |=> !o_out_valid)

endmodule

bind one_pole_tpt_filter opt_checker u_opt_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_lowpass_out  (o_lowpass_out),
    .o_highpass_out (o_highpass_out),
    .o_selected_out (o_selected_out)
);
